// ===== rtl/psir_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psir_pkg: shared types for the pair set insert/remove unit
// Request and response payloads, status codes and sequencer states.
// ----------------------------------------------------------------------------
package psir_pkg;

   // default number of table entries
   localparam int CAPACITY_DEFAULT = 1024;

   // field widths fixed by the request and response formats
   localparam int PART_WIDTH = 32;
   localparam int KEY_WIDTH  = 2 * PART_WIDTH;
   localparam int OCC_WIDTH  = 11;

   typedef enum logic [2:0] {
      ST_ADDED    = 3'd0,
      ST_PRESENT  = 3'd1,
      ST_REMOVED  = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT
   } state_type;

   localparam logic MODE_ADD    = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   typedef struct packed {
      logic                         mode;
      logic signed [PART_WIDTH-1:0] entry_real;
      logic signed [PART_WIDTH-1:0] entry_imag;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [OCC_WIDTH-1:0] occupancy;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/psir_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psir_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module psir_ram #(
   parameter int WIDTH      = 64,
   parameter int DEPTH      = 1024,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_WIDTH-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_WIDTH-1:0] rd_addr,
   output logic      [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/pair_set_insert_remove_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pair_set_insert_remove_unit: set of distinct (real, imag) pairs
// Keeps the pairs compact in one RAM; add appends after a full scan, remove
// finds the first match and shifts later entries down by one place.
// ----------------------------------------------------------------------------
//
//  channel   ports                       handshake
//  request   start, busy, req_data       taken when start && !busy
//  response  rsp_valid, rsp_data         one-cycle strobe, cannot be held off
//
//  Operation: the scan reads one RAM entry a cycle through the registered read
//  port, and a removal keeps streaming from the match to the end, writing each
//  entry one place lower.
//  Reset clears the count and the control state; the RAM is not cleared, entries at or above
//  the count are never read. The response is registered, so a new request
//  may start in the cycle the strobe is high.
//
module pair_set_insert_remove_unit
   import psir_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         issue_ff, issue_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [AW-1:0]         pend_addr_ff, pend_addr_in;
   logic [KEY_WIDTH-1:0]  key_ff, key_in;
   logic                  mode_ff, mode_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [KEY_WIDTH-1:0]  ram_wr_data;
   logic                  ram_rd_en;
   logic [KEY_WIDTH-1:0]  ram_rd_data;

   logic                  accept;
   logic                  can_issue;
   logic                  hit;
   logic                  drained;

   psir_ram #(
      .WIDTH      (KEY_WIDTH),
      .DEPTH      (CAPACITY),
      .ADDR_WIDTH (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // decode the read pipeline
   assign accept    = start && !busy;
   assign can_issue = (state_ff != S_IDLE) && (issue_ff < count_ff);
   assign hit       = (state_ff == S_SCAN) && pend_valid_ff && (ram_rd_data == key_ff);
   assign drained   = !pend_valid_ff && !can_issue;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit) begin
               state_in = (mode_ff == MODE_REMOVE) ? S_SHIFT : S_IDLE;
            end else if (drained) begin
               state_in = S_IDLE;
            end
         end
         S_SHIFT: begin
            if (drained) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in      = count_ff;
      key_in        = key_ff;
      mode_in       = mode_ff;
      issue_in      = can_issue ? CW'(issue_ff + 1'b1) : issue_ff;
      pend_valid_in = can_issue;
      pend_addr_in  = issue_ff[AW-1:0];
      ram_rd_en     = can_issue;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = count_ff[AW-1:0];
      ram_wr_data   = key_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            // latch the request and rewind the scan
            if (accept) begin
               key_in   = {req_data.entry_real, req_data.entry_imag};
               mode_in  = req_data.mode;
               issue_in = '0;
            end
         end
         S_SCAN: begin
            if (hit) begin
               // add of a held pair ends here; remove carries on shifting
               if (mode_ff == MODE_ADD) begin
                  rsp_valid_in     = 1'b1;
                  rsp_in.status    = ST_PRESENT;
                  rsp_in.occupancy = OCC_WIDTH'(count_ff);
               end
            end else if (drained) begin
               rsp_valid_in = 1'b1;
               if (mode_ff == MODE_REMOVE) begin
                  rsp_in.status    = ST_NOTFOUND;
                  rsp_in.occupancy = OCC_WIDTH'(count_ff);
               end else if (count_ff == FULL_COUNT) begin
                  rsp_in.status    = ST_FULL;
                  rsp_in.occupancy = OCC_WIDTH'(count_ff);
               end else begin
                  // append at the end
                  ram_wr_en        = 1'b1;
                  count_in         = CW'(count_ff + 1'b1);
                  rsp_in.status    = ST_ADDED;
                  rsp_in.occupancy = OCC_WIDTH'(count_ff + 1'b1);
               end
            end
         end
         S_SHIFT: begin
            // move each returned entry one place down
            if (pend_valid_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = AW'(pend_addr_ff - 1'b1);
               ram_wr_data = ram_rd_data;
            end
            if (drained) begin
               count_in         = CW'(count_ff - 1'b1);
               rsp_valid_in     = 1'b1;
               rsp_in.status    = ST_REMOVED;
               rsp_in.occupancy = OCC_WIDTH'(count_ff - 1'b1);
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         issue_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         issue_ff      <= issue_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      key_ff       <= key_in;
      mode_ff      <= mode_in;
      rsp_ff       <= rsp_in;
   end

   // checks
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("pair count above capacity");

   a_count_with_rsp : assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> rsp_valid_ff)
      else $error("count changed without a response");

   a_rsp_after_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) != S_IDLE)
      else $error("response without a request in flight");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted request did not raise busy");

   a_shift_no_overlap : assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && ram_rd_en) |-> ram_wr_addr != issue_ff[AW-1:0])
      else $error("read and write of the same entry in one cycle");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the pair set insert/remove unit
// Drives add and remove requests, first a directed set of edge cases, then
// random traffic over a small key pool. A scoreboard keeps its own copy of
// the set, predicts the status and occupancy of every accepted request and
// compares each response.
// ----------------------------------------------------------------------------
module tb_top;
   import psir_pkg::*;

   localparam int CAPACITY     = CAPACITY_DEFAULT;
   localparam int POOL_SIZE    = 40;
   localparam int RANDOM_ITEMS = 560;
   localparam int MAX_GAP      = 12;
   localparam int REPORT_CAP   = 100;
   // bound on all requests sent, directed phase included
   localparam int ITEM_BOUND   = 700;
   // every request at a full scan plus the longest gap, taken three times over
   localparam longint CYCLE_LIMIT = 3 * ITEM_BOUND * (CAPACITY + 3 + MAX_GAP + 4);

   localparam logic [PART_WIDTH-1:0] PART_MIN  = 32'h8000_0000;
   localparam logic [PART_WIDTH-1:0] PART_MAX  = 32'h7FFF_FFFF;
   localparam logic [PART_WIDTH-1:0] PART_ZERO = 32'h0000_0000;
   localparam logic [PART_WIDTH-1:0] PART_ONES = 32'hFFFF_FFFF;
   localparam logic [PART_WIDTH-1:0] PART_ONE  = 32'h0000_0001;

   // Shadow copy of the pair set and the queue of predicted responses.
   class pair_set_scoreboard;
      int                  capacity;
      bit [KEY_WIDTH-1:0]  held_pairs[$];
      rsp_type             expected_rsps[$];
      int                  fail_count;

      function new(int cap);
         capacity   = cap;
         fail_count = 0;
      endfunction

      // Apply one accepted request to the shadow set and queue its response.
      function void note_request(req_type r);
         bit [KEY_WIDTH-1:0] key;
         int                 pos;
         rsp_type            want;
         key = {r.entry_real, r.entry_imag};
         pos = -1;
         for (int i = 0; i < held_pairs.size() && pos < 0; i++) begin
            if (held_pairs[i] == key) pos = i;
         end
         if (r.mode == MODE_ADD) begin
            if (pos >= 0) begin
               want.status = ST_PRESENT;
            end else if (held_pairs.size() >= capacity) begin
               want.status = ST_FULL;
            end else begin
               held_pairs.push_back(key);
               want.status = ST_ADDED;
            end
         end else begin
            if (pos >= 0) begin
               held_pairs.delete(pos);
               want.status = ST_REMOVED;
            end else begin
               want.status = ST_NOTFOUND;
            end
         end
         want.occupancy = OCC_WIDTH'(held_pairs.size());
         expected_rsps.push_back(want);
      endfunction

      // Compare one response against the oldest prediction.
      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_rsps.size() == 0) begin
            if (fail_count < REPORT_CAP)
               $display("%0t: response with none pending, status %0d occupancy %0d",
                        $time, got.status, got.occupancy);
            fail_count++;
            return;
         end
         want = expected_rsps.pop_front();
         if (got.status !== want.status) begin
            if (fail_count < REPORT_CAP)
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, got.status);
            fail_count++;
         end
         if (got.occupancy !== want.occupancy) begin
            if (fail_count < REPORT_CAP)
               $display("%0t: occupancy expected %0d actual %0d",
                        $time, want.occupancy, got.occupancy);
            fail_count++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   pair_set_scoreboard pair_sb;
   bit                 idle_enable;
   longint             cycle_count = 0;
   bit [KEY_WIDTH-1:0] key_pool[POOL_SIZE];

   pair_set_insert_remove_unit #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Check every response strobe.
   always @(posedge clock) begin
      if (!reset && rsp_valid) pair_sb.check_response(rsp_data);
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Hold start low for a random gap, sometimes starting it only once the unit is idle.
   task automatic idle_gap();
      int n;
      n = $urandom_range(1, MAX_GAP);
      @(negedge clock);
      start <= 1'b0;
      if ($urandom_range(0, 1)) begin
         while (busy) @(negedge clock);
      end
      repeat (n) @(negedge clock);
   endtask

   // Present one request and wait until the unit takes it.
   task automatic do_request(input logic m, input bit [KEY_WIDTH-1:0] key);
      req_type r;
      r.mode       = m;
      r.entry_real = key[KEY_WIDTH-1:PART_WIDTH];
      r.entry_imag = key[PART_WIDTH-1:0];
      if (idle_enable && $urandom_range(0, 99) < 30) idle_gap();
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      pair_sb.note_request(r);
   endtask

   // Drop start and hold until every predicted response has arrived.
   task automatic wait_all_done();
      @(negedge clock);
      start <= 1'b0;
      while (pair_sb.expected_rsps.size() != 0) @(posedge clock);
   endtask

   function automatic bit [PART_WIDTH-1:0] edge_part();
      case ($urandom_range(0, 4))
         0:       return PART_MIN;
         1:       return PART_MAX;
         2:       return PART_ZERO;
         3:       return PART_ONES;
         default: return PART_ONE;
      endcase
   endfunction

   // Mostly pool keys so adds and removes collide, some held, some fresh.
   function automatic bit [KEY_WIDTH-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (r < 75 && pair_sb.held_pairs.size() > 0)
         return pair_sb.held_pairs[$urandom_range(0, pair_sb.held_pairs.size() - 1)];
      return {$urandom, $urandom};
   endfunction

   initial begin
      pair_sb     = new(CAPACITY);
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      idle_enable = 1'b1;

      // build a pool with shared real parts, shared imaginary parts and edges
      for (int i = 0; i < POOL_SIZE; i++) begin
         case (i % 4)
            0:       key_pool[i] = {$urandom, $urandom};
            1:       key_pool[i] = {key_pool[i-1][KEY_WIDTH-1:PART_WIDTH], $urandom};
            2:       key_pool[i] = {$urandom, key_pool[i-2][PART_WIDTH-1:0]};
            default: key_pool[i] = {edge_part(), edge_part()};
         endcase
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, extremes, duplicates, near misses, positions
      do_request(MODE_REMOVE, {PART_ZERO, PART_ZERO});
      do_request(MODE_ADD,    {PART_MIN,  PART_MIN});
      do_request(MODE_ADD,    {PART_MAX,  PART_MAX});
      do_request(MODE_ADD,    {PART_ZERO, PART_ZERO});
      do_request(MODE_ADD,    {PART_ONES, PART_ONES});
      do_request(MODE_ADD,    {PART_MAX,  PART_MIN});
      do_request(MODE_ADD,    {PART_MIN,  PART_MAX});
      do_request(MODE_ADD,    {PART_MIN,  PART_MIN});
      do_request(MODE_ADD,    {PART_ZERO, PART_ONES});
      do_request(MODE_ADD,    {PART_ONES, PART_ZERO});
      do_request(MODE_REMOVE, {PART_ZERO, PART_ONE});
      do_request(MODE_REMOVE, {PART_ONE,  PART_ZERO});
      do_request(MODE_REMOVE, {PART_MIN,  PART_MIN});
      do_request(MODE_REMOVE, {PART_ONES, PART_ZERO});
      do_request(MODE_REMOVE, {PART_ZERO, PART_ZERO});
      do_request(MODE_REMOVE, {PART_ZERO, PART_ZERO});
      do_request(MODE_ADD,    {PART_ZERO, PART_ZERO});
      do_request(MODE_ADD,    {32'hAAAA_AAAA, 32'h5555_5555});
      do_request(MODE_ADD,    {32'h5555_5555, 32'hAAAA_AAAA});
      do_request(MODE_REMOVE, {PART_MAX,  PART_MAX});
      do_request(MODE_ADD,    {PART_MAX,  PART_MAX});

      // let the unit drain completely before the random traffic
      wait_all_done();

      // random traffic, with one stretch of back-to-back requests
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         idle_enable = !(i >= 250 && i < 350);
         do_request(1'($urandom_range(0, 1)), pick_key());
      end
      idle_enable = 1'b1;

      // wait out the last responses and watch for strays
      wait_all_done();
      repeat (CAPACITY + 8) @(posedge clock);

      if (pair_sb.fail_count == 0 && pair_sb.expected_rsps.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/psir_pkg.sv
rtl/psir_ram.sv
rtl/pair_set_insert_remove_unit.sv
verif/tb_top.sv
